// File: design/lrs_pkg.sv
`default_nettype none
package lrs_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS = 16;
   localparam int COUNT_BITS = 11;
   localparam int POS_BITS = 10;
   localparam int PHASE_BITS = 26;
   localparam int MAX_LEN = 1024;
   localparam int MAX_OUT_PER_SAMPLE = 64;
   localparam int BURST_BITS = 7;
   localparam int DIV_STEPS = PHASE_BITS;
   localparam int DIV_CNT_BITS = 5;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IN_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_COUNT = 2'd1;

   localparam logic [COUNT_BITS-1:0] IN_COUNT_RESET = 11'd200;
   localparam logic [COUNT_BITS-1:0] OUT_COUNT_RESET = 11'd740;

   // controller to datapath
   typedef struct packed {
      logic calc;        // derive effective counts, load divider
      logic div_step;    // one restoring division step
      logic accept;      // capture incoming word
      logic emit_load;   // register interpolation product
      logic out_load;    // load result register, advance phase
      logic finish;      // close out current input word
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cfg_write;
      logic div_last;
      logic emit_ok;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// File: design/lrs_ctrl.sv
`default_nettype none
module lrs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire lrs_pkg::status_type status,
   output lrs_pkg::cmd_type        cmd
);

   localparam logic [2:0] S_CALC  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_IDLE  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.emit_ok) begin
               cmd.emit_load = 1'b1;
               state_in = S_EMIT;
            end else begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            // hold while the result register is still occupied
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_CHECK;
            end
         end
         default: begin
            state_in = S_CALC;
         end
      endcase
      // a register write restarts the step computation
      if (status.cfg_write) begin
         state_in = S_CALC;
         cmd.accept = 1'b0;
         cmd.emit_load = 1'b0;
         cmd.out_load = 1'b0;
         cmd.finish = 1'b0;
         req_ready = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CALC;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: design/lrs_datapath.sv
`default_nettype none
module lrs_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [lrs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lrs_pkg::COUNT_BITS-1:0]      csr_write_data,
   input  wire logic signed [lrs_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic signed [lrs_pkg::SAMPLE_BITS-1:0]   rsp_sample_out,
   output logic                                     rsp_frame_end,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire lrs_pkg::cmd_type                    cmd,
   output lrs_pkg::status_type                      status
);

   localparam int SB = lrs_pkg::SAMPLE_BITS;
   localparam int FB = lrs_pkg::FRAC_BITS;
   localparam int CB = lrs_pkg::COUNT_BITS;
   localparam int PB = lrs_pkg::POS_BITS;
   localparam int AB = lrs_pkg::PHASE_BITS;
   localparam int NB = lrs_pkg::BURST_BITS;
   localparam int DB = lrs_pkg::DIV_CNT_BITS;
   localparam int PRODB = SB + FB + 1;

   // configuration
   logic [CB-1:0] in_count_ff, in_count_in;
   logic [CB-1:0] out_count_ff, out_count_in;
   logic [CB-1:0] eff_in_ff, eff_in_in;
   logic [CB-1:0] eff_out_ff, eff_out_in;

   // divider; dq holds the dividend, then the quotient (phase step)
   logic [AB-1:0] dq_ff, dq_in;
   logic [PB-1:0] rem_ff, rem_in;
   logic [PB-1:0] divisor_ff, divisor_in;
   logic [DB-1:0] div_cnt_ff, div_cnt_in;

   // frame state
   logic signed [SB-1:0] prev_ff, prev_in;
   logic signed [SB-1:0] x_ff, x_in;
   logic [PB-1:0] in_pos_ff, in_pos_in;
   logic [CB-1:0] out_pos_ff, out_pos_in;
   logic [AB-1:0] phase_ff, phase_in;
   logic [NB-1:0] burst_ff, burst_in;

   // interpolation
   logic signed [PRODB-1:0] prod_ff, prod_in;
   logic take_x_ff, take_x_in;

   // result register
   logic signed [SB-1:0] rsp_sample_ff, rsp_sample_in;
   logic rsp_end_ff, rsp_end_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic cfg_hit;
   logic [CB-1:0] ein_c;
   logic [CB+5:0] hi_wide;
   logic [CB-1:0] hi_c;
   logic [CB-1:0] eout_c;
   logic [CB-1:0] ein_m1;
   logic [PB:0] rem_sh;
   logic [PB:0] rem_diff;
   logic rem_ge;
   logic [PB-1:0] idx;
   logic [PB-1:0] p_m1;
   logic hit_prev, hit_last;
   logic signed [SB:0] diff;
   logic signed [SB:0] frac_s;
   logic signed [2*SB+1:0] prod_full;
   logic signed [SB:0] y_wide;
   logic [CB-1:0] out_pos_nx;
   logic [PB:0] in_pos_nx;

   assign cfg_hit = csr_write_enable &&
                    (csr_index == lrs_pkg::CSR_IN_COUNT || csr_index == lrs_pkg::CSR_OUT_COUNT);

   // clamp the counts
   always_comb begin
      ein_c = in_count_ff;
      if (in_count_ff < CB'(2)) begin
         ein_c = CB'(2);
      end else if (in_count_ff > CB'(lrs_pkg::MAX_LEN)) begin
         ein_c = CB'(lrs_pkg::MAX_LEN);
      end
      ein_m1 = ein_c - CB'(1);
      hi_wide = (CB+6)'(ein_m1) * (CB+6)'(lrs_pkg::MAX_OUT_PER_SAMPLE - 1) + (CB+6)'(1);
      if (hi_wide > (CB+6)'(lrs_pkg::MAX_LEN)) begin
         hi_c = CB'(lrs_pkg::MAX_LEN);
      end else begin
         hi_c = hi_wide[CB-1:0];
      end
      eout_c = out_count_ff;
      if (out_count_ff < CB'(2)) begin
         eout_c = CB'(2);
      end else if (out_count_ff > hi_c) begin
         eout_c = hi_c;
      end
   end

   // restoring division step
   assign rem_sh = {rem_ff, dq_ff[AB-1]};
   assign rem_ge = rem_sh >= {1'b0, divisor_ff};
   assign rem_diff = rem_sh - {1'b0, divisor_ff};

   // position tests
   assign idx = phase_ff[AB-1:FB];
   assign p_m1 = in_pos_ff - PB'(1);
   assign hit_prev = idx == p_m1;
   assign hit_last = (idx == in_pos_ff) && ({1'b0, in_pos_ff} == eff_in_ff - CB'(1));

   assign diff = {x_ff[SB-1], x_ff} - {prev_ff[SB-1], prev_ff};
   assign frac_s = $signed({1'b0, phase_ff[FB-1:0]});
   assign prod_full = diff * frac_s;
   assign y_wide = {prev_ff[SB-1], prev_ff} + prod_ff[PRODB-1:FB];
   assign out_pos_nx = out_pos_ff + CB'(1);
   assign in_pos_nx = {1'b0, in_pos_ff} + (PB+1)'(1);

   always_comb begin
      status.cfg_write = cfg_hit;
      status.div_last = div_cnt_ff == DB'(lrs_pkg::DIV_STEPS - 1);
      status.emit_ok = (in_pos_ff != '0) && (out_pos_ff < eff_out_ff) &&
                       (burst_ff < NB'(lrs_pkg::MAX_OUT_PER_SAMPLE)) && (hit_prev || hit_last);
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      in_count_in = in_count_ff;
      out_count_in = out_count_ff;
      eff_in_in = eff_in_ff;
      eff_out_in = eff_out_ff;
      dq_in = dq_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      div_cnt_in = div_cnt_ff;
      prev_in = prev_ff;
      x_in = x_ff;
      in_pos_in = in_pos_ff;
      out_pos_in = out_pos_ff;
      phase_in = phase_ff;
      burst_in = burst_ff;
      prod_in = prod_ff;
      take_x_in = take_x_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_end_in = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.calc) begin
         eff_in_in = ein_c;
         eff_out_in = eout_c;
         dq_in = {ein_m1[PB-1:0], {FB{1'b0}}};
         divisor_in = PB'(eout_c - CB'(1));
         rem_in = '0;
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         dq_in = {dq_ff[AB-2:0], rem_ge};
         rem_in = rem_ge ? rem_diff[PB-1:0] : rem_sh[PB-1:0];
         div_cnt_in = div_cnt_ff + DB'(1);
      end
      if (cmd.accept) begin
         x_in = req_sample_in;
         burst_in = '0;
      end
      if (cmd.emit_load) begin
         prod_in = prod_full[PRODB-1:0];
         take_x_in = !hit_prev;
      end
      if (cmd.out_load) begin
         rsp_sample_in = take_x_ff ? x_ff : y_wide[SB-1:0];
         rsp_end_in = out_pos_nx == eff_out_ff;
         rsp_valid_in = 1'b1;
         out_pos_in = out_pos_nx;
         phase_in = phase_ff + dq_ff;
         burst_in = burst_ff + NB'(1);
      end
      if (cmd.finish) begin
         prev_in = x_ff;
         // wrap to a new frame after the last input word
         if (in_pos_nx >= eff_in_ff) begin
            in_pos_in = '0;
            out_pos_in = '0;
            phase_in = '0;
         end else begin
            in_pos_in = in_pos_nx[PB-1:0];
         end
      end
      if (csr_write_enable && csr_index == lrs_pkg::CSR_IN_COUNT) begin
         in_count_in = csr_write_data;
      end
      if (csr_write_enable && csr_index == lrs_pkg::CSR_OUT_COUNT) begin
         out_count_in = csr_write_data;
      end
      if (cfg_hit) begin
         prev_in = '0;
         in_pos_in = '0;
         out_pos_in = '0;
         phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff <= lrs_pkg::IN_COUNT_RESET;
         out_count_ff <= lrs_pkg::OUT_COUNT_RESET;
         eff_in_ff <= lrs_pkg::IN_COUNT_RESET;
         eff_out_ff <= lrs_pkg::OUT_COUNT_RESET;
         div_cnt_ff <= '0;
         prev_ff <= '0;
         in_pos_ff <= '0;
         out_pos_ff <= '0;
         phase_ff <= '0;
         burst_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_count_ff <= in_count_in;
         out_count_ff <= out_count_in;
         eff_in_ff <= eff_in_in;
         eff_out_ff <= eff_out_in;
         div_cnt_ff <= div_cnt_in;
         prev_ff <= prev_in;
         in_pos_ff <= in_pos_in;
         out_pos_ff <= out_pos_in;
         phase_ff <= phase_in;
         burst_ff <= burst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
      x_ff <= x_in;
      prod_ff <= prod_in;
      take_x_ff <= take_x_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_end_ff <= rsp_end_in;
   end

   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_frame_end = rsp_end_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: design/linear_resampler_unit.sv
// Linear interpolation resampler: each frame of in_count signed 16-bit words
// on the req_ channel becomes out_count interpolated words on the rsp_ channel,
// rsp_frame_end marking the last word of a frame. Both channels use
// valid/ready. Register writes (csr_index 0: in_count, 1: out_count) clamp the
// counts, restart the frame and recompute the Q16 phase step with a restoring
// divider, one quotient bit per cycle: req_ready stays low after reset or after
// any register write until the division is done.
// Per input word: one accept step, then for each result produced a product
// register step and a result register step, then one closing step. The first
// word of a frame releases no result.
// Results leave through a single output register; when the receiver stalls,
// the block finishes its current product and holds until that register is
// taken, and accepts no new word until the current one is closed out.
`default_nettype none
module linear_resampler_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [lrs_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [lrs_pkg::SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic                                        rsp_frame_end,
   input  wire logic                                   csr_write_enable,
   input  wire logic [lrs_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [lrs_pkg::COUNT_BITS-1:0]         csr_write_data
);

   lrs_pkg::cmd_type    cmd;
   lrs_pkg::status_type status;

   lrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_sample_in    (req_sample_in),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
`default_nettype wire
